// ----- hw/rtl/dspf_pkg.sv -----
// shared constants for the dual servo pwm block
package dspf_pkg;

    localparam logic [15:0] MAGIC_WORD = 16'hFFEE;
    localparam logic [15:0] COORD_MAX  = 16'd1023;
    localparam logic [15:0] BUTTON_MAX = 16'd1;

    // deadband windows and the centre value each window snaps to
    localparam logic [12:0] X_BAND_LO  = 13'd500;
    localparam logic [12:0] X_BAND_HI  = 13'd520;
    localparam logic [12:0] X_CENTRE   = 13'd510;
    localparam logic [12:0] Y_BAND_LO  = 13'd486;
    localparam logic [12:0] Y_BAND_HI  = 13'd506;
    localparam logic [12:0] Y_CENTRE   = 13'd500;

    // divide by 100 as multiply by ceil(2^21 / 100), exact for 13-bit inputs
    localparam int          DIV_SHIFT  = 21;
    localparam logic [14:0] DIV_RECIP  = 15'd20972;

    localparam logic [9:0]  X_RESET_POS = 10'd510;
    localparam logic [9:0]  Y_RESET_POS = 10'd496;

    localparam logic [7:0]  PERIOD_RESET = 8'd156;
    localparam logic [4:0]  OFFSET_RESET = 5'd17;
    localparam logic [14:0] DELAY_RESET  = 15'd15625;

    typedef enum logic [1:0] {
        CFG_PWM_PERIOD   = 2'd0,
        CFG_PULSE_OFFSET = 2'd1,
        CFG_FREEZE_DELAY = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_MESSAGE = 1'b1;

endpackage

// ----- hw/rtl/dual_servo_pwm_with_freeze.sv -----
// dual channel servo pwm generator with button toggle and delayed compare freeze
//
//  channel  | signals                                         | dir | notes
//  ---------+-------------------------------------------------+-----+---------------------------
//  input    | in_valid/in_ready, operation, magic_word,       | in  | tick or joystick message
//           | x_value, y_value, button_value                  |     |
//  output   | out_valid/out_ready, x_drive, y_drive,          | out | one result per transaction
//           | toggle_out, frozen, message_accepted            |     |
//  config   | cfg_valid/cfg_ready, cfg_index, cfg_data        | in  | always ready, idle writes only
//
// one transaction per cycle unless the output stalls; path is input register, then result register
// all per-item work is compare, add and one small constant multiply per channel for the divide by 100
// reset clears valid and state registers (positions to reset values); config returns to its default values
// a stall on the output holds the result register, then the input register, then in_ready

module dual_servo_pwm_with_freeze #(
    parameter int COORD_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [15:0] magic_word,
    input  logic [15:0] x_value,
    input  logic [15:0] y_value,
    input  logic [15:0] button_value,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        x_drive,
    output logic        y_drive,
    output logic        toggle_out,
    output logic        frozen,
    output logic        message_accepted,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    localparam logic [COORD_BITS-1:0] X_RESET = COORD_BITS'(dspf_pkg::X_RESET_POS);
    localparam logic [COORD_BITS-1:0] Y_RESET = COORD_BITS'(dspf_pkg::Y_RESET_POS);

    // configuration registers
    logic [7:0]  period_reg;
    logic [4:0]  offset_reg;
    logic [14:0] delay_reg;

    // input register stage
    logic        s1_valid_reg;
    logic        s1_op_reg;
    logic [15:0] s1_magic_reg;
    logic [15:0] s1_x_reg;
    logic [15:0] s1_y_reg;
    logic [15:0] s1_button_reg;

    // block state
    logic [7:0]            tick_count_reg,   tick_count_next;
    logic [COORD_BITS-1:0] x_pos_reg,        x_pos_next;
    logic [COORD_BITS-1:0] y_pos_reg,        y_pos_next;
    logic                  pending_reg,      pending_next;
    logic [4:0]            x_cmp_reg,        x_cmp_next;
    logic [4:0]            y_cmp_reg,        y_cmp_next;
    logic                  x_level_reg,      x_level_next;
    logic                  y_level_reg,      y_level_next;
    logic                  toggle_reg,       toggle_next;
    logic                  freeze_reg,       freeze_next;
    logic                  wait_reg,         wait_next;
    logic [14:0]           wait_count_reg,   wait_count_next;
    logic                  accepted_next;

    // result register
    logic out_valid_reg;
    logic x_drive_reg;
    logic y_drive_reg;
    logic toggle_out_reg;
    logic frozen_reg;
    logic accepted_reg;

    logic advance;
    logic msg_ok;
    logic [8:0] count_inc;
    logic [14:0] wait_inc;

    // position to compare value: deadband snap, divide by 100, saturating subtract
    function automatic logic [4:0] map_pos(
        input logic [COORD_BITS-1:0] pos,
        input logic [12:0]           lo,
        input logic [12:0]           hi,
        input logic [12:0]           centre,
        input logic [4:0]            offset
    );
        logic [12:0] p;
        logic [12:0] v;
        logic [27:0] prod;
        logic [6:0]  d;
        p    = 13'(pos);
        v    = (p >= lo && p <= hi) ? centre : p;
        prod = 28'(v) * 28'(dspf_pkg::DIV_RECIP);
        d    = prod[27:dspf_pkg::DIV_SHIFT];
        return (d >= 7'(offset)) ? 5'd0 : 5'(7'(offset) - d);
    endfunction

    // the pipeline moves when stage one holds an item and the result slot frees up
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid        = out_valid_reg;
    assign x_drive          = x_drive_reg;
    assign y_drive          = y_drive_reg;
    assign toggle_out       = toggle_out_reg;
    assign frozen           = frozen_reg;
    assign message_accepted = accepted_reg;

    // message check
    assign msg_ok = (s1_magic_reg == dspf_pkg::MAGIC_WORD)
                 && (s1_x_reg <= dspf_pkg::COORD_MAX)
                 && (s1_y_reg <= dspf_pkg::COORD_MAX)
                 && (s1_button_reg <= dspf_pkg::BUTTON_MAX);

    assign count_inc = 9'(tick_count_reg) + 9'd1;

    // single pass update for one transaction
    always_comb
    begin
        tick_count_next = tick_count_reg;
        x_pos_next      = x_pos_reg;
        y_pos_next      = y_pos_reg;
        pending_next    = pending_reg;
        x_cmp_next      = x_cmp_reg;
        y_cmp_next      = y_cmp_reg;
        x_level_next    = x_level_reg;
        y_level_next    = y_level_reg;
        toggle_next     = toggle_reg;
        freeze_next     = freeze_reg;
        wait_next       = wait_reg;
        wait_count_next = wait_count_reg;
        accepted_next   = 1'b0;
        wait_inc        = 15'd0;

        if (s1_op_reg == dspf_pkg::OP_MESSAGE)
        begin
            if (msg_ok)
            begin
                x_pos_next    = s1_x_reg[COORD_BITS-1:0];
                y_pos_next    = s1_y_reg[COORD_BITS-1:0];
                pending_next  = s1_button_reg[0];
                accepted_next = 1'b1;
            end
        end
        else
        begin
            // compares track the positions until frozen
            if (!freeze_reg)
            begin
                x_cmp_next = map_pos(x_pos_reg, dspf_pkg::X_BAND_LO, dspf_pkg::X_BAND_HI,
                                     dspf_pkg::X_CENTRE, offset_reg);
                y_cmp_next = map_pos(y_pos_reg, dspf_pkg::Y_BAND_LO, dspf_pkg::Y_BAND_HI,
                                     dspf_pkg::Y_CENTRE, offset_reg);
            end

            // pending button flips the aux output and clears the freeze; turning on restarts the wait
            if (pending_reg)
            begin
                toggle_next  = !toggle_reg;
                freeze_next  = 1'b0;
                wait_next    = !toggle_reg;
                pending_next = 1'b0;
                if (!toggle_reg)
                begin
                    wait_count_next = 15'd0;
                end
            end

            // frame counter wraps at the period
            tick_count_next = (count_inc >= 9'(period_reg)) ? 8'd0 : count_inc[7:0];

            if (tick_count_next == 8'd0)
            begin
                x_level_next = 1'b1;
                y_level_next = 1'b1;
            end
            if (tick_count_next == 8'(x_cmp_next))
            begin
                x_level_next = 1'b0;
            end
            if (tick_count_next == 8'(y_cmp_next))
            begin
                y_level_next = 1'b0;
            end

            // delay toward freeze
            if (wait_next)
            begin
                wait_inc        = wait_count_next + 15'd1;
                wait_count_next = wait_inc;
                if (wait_inc == delay_reg)
                begin
                    freeze_next = 1'b1;
                    wait_next   = 1'b0;
                end
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= dspf_pkg::PERIOD_RESET;
            offset_reg <= dspf_pkg::OFFSET_RESET;
            delay_reg  <= dspf_pkg::DELAY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dspf_pkg::CFG_PWM_PERIOD:   period_reg <= cfg_data[7:0];
                dspf_pkg::CFG_PULSE_OFFSET: offset_reg <= cfg_data[4:0];
                dspf_pkg::CFG_FREEZE_DELAY: delay_reg  <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // input register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_op_reg     <= operation;
            s1_magic_reg  <= magic_word;
            s1_x_reg      <= x_value;
            s1_y_reg      <= y_value;
            s1_button_reg <= button_value;
        end
    end

    // state update and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= 8'd0;
            x_pos_reg      <= X_RESET;
            y_pos_reg      <= Y_RESET;
            pending_reg    <= 1'b0;
            x_cmp_reg      <= 5'd0;
            y_cmp_reg      <= 5'd0;
            x_level_reg    <= 1'b0;
            y_level_reg    <= 1'b0;
            toggle_reg     <= 1'b0;
            freeze_reg     <= 1'b0;
            wait_reg       <= 1'b0;
            wait_count_reg <= 15'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                tick_count_reg <= tick_count_next;
                x_pos_reg      <= x_pos_next;
                y_pos_reg      <= y_pos_next;
                pending_reg    <= pending_next;
                x_cmp_reg      <= x_cmp_next;
                y_cmp_reg      <= y_cmp_next;
                x_level_reg    <= x_level_next;
                y_level_reg    <= y_level_next;
                toggle_reg     <= toggle_next;
                freeze_reg     <= freeze_next;
                wait_reg       <= wait_next;
                wait_count_reg <= wait_count_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_drive_reg    <= x_level_next;
            y_drive_reg    <= y_level_next;
            toggle_out_reg <= toggle_next;
            frozen_reg     <= freeze_next;
            accepted_reg   <= accepted_next;
        end
    end

endmodule
